// ===== src/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers used by the top-level RTL file.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a condition implies another in the same cycle.
`define ASSERT_SAME(name, clk, rstn, pre, post, msg) \
    name: assert property (@(posedge clk) disable iff (!(rstn)) (pre) |-> (post)) \
        else $error(msg);

// Check that a condition implies another in the following cycle.
`define ASSERT_NEXT(name, clk, rstn, pre, post, msg) \
    name: assert property (@(posedge clk) disable iff (!(rstn)) (pre) |=> (post)) \
        else $error(msg);

`endif

// ===== src/ttcw_pkg.sv =====
// ----------------------------------------------------------------------------
// ttcw_pkg
// Shared codes, defaults and controller/datapath types of the cell writer.
// ----------------------------------------------------------------------------
`default_nettype none

package ttcw_pkg;

    // Default grid size
    localparam int TTCW_COLS = 80;
    localparam int TTCW_ROWS = 30;

    // Command codes
    localparam logic [1:0] CMD_PUT   = 2'd0;
    localparam logic [1:0] CMD_KEY   = 2'd1;
    localparam logic [1:0] CMD_CLEAR = 2'd2;
    localparam logic [1:0] CMD_READ  = 2'd3;

    // Character codes
    localparam logic [7:0] CH_BS    = 8'h08;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TILDE = 8'h7E;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_EXEC,
        ST_READ,
        ST_SCROLL,
        ST_POST,
        ST_CLEAR
    } ttcw_state_t;

    // What the held beat needs once decoded
    typedef enum logic [1:0] {
        PLAN_SIMPLE,
        PLAN_READ,
        PLAN_SCROLL,
        PLAN_CLEAR
    } ttcw_plan_t;

    typedef struct packed {
        logic item_load;
        logic simple_commit;
        logic read_issue;
        logic read_finish;
        logic sweep_step;
        logic sweep_one_row;
        logic scroll_finish;
        logic clear_finish;
    } ttcw_cmd_t;

    typedef struct packed {
        ttcw_plan_t plan;
        logic       out_free;
        logic       col_end;
        logic       all_end;
    } ttcw_stat_t;

endpackage

`default_nettype wire

// ===== src/ttcw_ctrl.sv =====
// ----------------------------------------------------------------------------
// ttcw_ctrl
// Sequencer of the cell writer: init sweep, decode, read, scroll and clear.
// ----------------------------------------------------------------------------
`default_nettype none

module ttcw_ctrl (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire ttcw_pkg::ttcw_stat_t stat,
    output ttcw_pkg::ttcw_cmd_t     cmd
);
    import ttcw_pkg::*;

    ttcw_state_t state_reg;
    ttcw_state_t state_next;

    // Hold state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_INIT;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_INIT: begin
                if (stat.all_end) state_next = ST_IDLE;
            end
            ST_IDLE: begin
                if (s_valid) state_next = ST_EXEC;
            end
            ST_EXEC: begin
                if (stat.out_free) begin
                    unique case (stat.plan)
                        PLAN_SIMPLE: state_next = ST_IDLE;
                        PLAN_READ:   state_next = ST_READ;
                        PLAN_SCROLL: state_next = ST_SCROLL;
                        PLAN_CLEAR:  state_next = ST_CLEAR;
                        default:     state_next = ST_IDLE;
                    endcase
                end
            end
            ST_READ:   state_next = ST_IDLE;
            ST_SCROLL: begin
                if (stat.col_end) state_next = ST_POST;
            end
            ST_POST:   state_next = ST_IDLE;
            ST_CLEAR: begin
                if (stat.all_end) state_next = ST_IDLE;
            end
            default:   state_next = ST_IDLE;
        endcase
    end

    // Commands
    always_comb begin
        cmd     = '0;
        s_ready = 1'b0;
        unique case (state_reg)
            ST_INIT: begin
                cmd.sweep_step = 1'b1;
            end
            ST_IDLE: begin
                s_ready       = 1'b1;
                cmd.item_load = s_valid;
            end
            ST_EXEC: begin
                if (stat.out_free) begin
                    cmd.simple_commit = (stat.plan == PLAN_SIMPLE);
                    cmd.read_issue    = (stat.plan == PLAN_READ);
                end
            end
            ST_READ: begin
                cmd.read_finish = 1'b1;
            end
            ST_SCROLL: begin
                cmd.sweep_step    = 1'b1;
                cmd.sweep_one_row = 1'b1;
            end
            ST_POST: begin
                cmd.scroll_finish = 1'b1;
            end
            ST_CLEAR: begin
                cmd.sweep_step   = 1'b1;
                cmd.clear_finish = stat.all_end;
            end
            default: begin
                cmd = '0;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== src/ttcw_dp.sv =====
// ----------------------------------------------------------------------------
// ttcw_dp
// Datapath of the cell writer: grid memory with a rotating top row, cursor,
// fill sweep counters, held input beat and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module ttcw_dp #(
    parameter int COLS = ttcw_pkg::TTCW_COLS,
    parameter int ROWS = ttcw_pkg::TTCW_ROWS
) (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic [1:0]                  s_cmd,
    input  wire logic [7:0]                  s_ch,
    input  wire logic [$clog2(ROWS)-1:0]     s_read_row,
    input  wire logic [$clog2(COLS)-1:0]     s_read_col,
    output logic                             m_valid,
    input  wire logic                        m_ready,
    output logic [$clog2(COLS+1)-1:0]        m_cursor_col,
    output logic [$clog2(ROWS)-1:0]          m_cursor_row,
    output logic [7:0]                       m_cell_char,
    output logic                             m_scrolled,
    input  wire ttcw_pkg::ttcw_cmd_t         cmd,
    output ttcw_pkg::ttcw_stat_t             stat
);
    import ttcw_pkg::*;

    localparam int ROW_W     = $clog2(ROWS);
    localparam int ROW_W1    = ROW_W + 1;
    localparam int COL_AW    = $clog2(COLS);
    localparam int CUR_CW    = $clog2(COLS + 1);
    localparam int MEM_DEPTH = ROWS << COL_AW;
    localparam int ADDR_W    = $clog2(MEM_DEPTH);

    localparam logic [ROW_W1-1:0] ROWS_L   = ROW_W1'(ROWS);
    localparam logic [ROW_W-1:0]  ROW_LAST = ROW_W'(ROWS - 1);
    localparam logic [CUR_CW-1:0] COLS_C   = CUR_CW'(COLS);
    localparam logic [COL_AW-1:0] COL_LAST = COL_AW'(COLS - 1);

    // Grid memory, addressed as {physical row, column}
    logic [7:0] mem [MEM_DEPTH];

    // Held input beat
    logic [1:0]        cmd_reg;
    logic [7:0]        ch_reg;
    logic [ROW_W-1:0]  rr_reg;
    logic [COL_AW-1:0] rc_reg;

    // Cursor and rotation
    logic [CUR_CW-1:0] col_reg,  col_next;
    logic [ROW_W-1:0]  row_reg,  row_next;
    logic [ROW_W-1:0]  top_reg,  top_next;

    // Fill sweep
    logic [COL_AW-1:0] sw_col_reg, sw_col_next;
    logic [ROW_W-1:0]  sw_row_reg, sw_row_next;

    // Status towards the controller
    ttcw_plan_t        plan_sel;
    logic              col_end;
    logic              all_end;
    logic              out_free;

    // Result register
    logic              m_valid_reg, m_valid_next;
    logic [CUR_CW-1:0] m_col_reg;
    logic [ROW_W-1:0]  m_row_reg;
    logic [7:0]        m_cell_reg;
    logic              m_sc_reg;
    logic              load;
    logic [CUR_CW-1:0] load_col;
    logic [ROW_W-1:0]  load_row;
    logic [7:0]        load_cell;
    logic              load_sc;

    logic [7:0]        rd_data_reg;

    // Decode
    logic              printable, put, put_lf, put_cr, put_wr, bs;
    logic [7:0]        pc;
    logic              line_full, at_bottom, rd_in_range;
    logic [ROW_W-1:0]  row_inc;
    logic [CUR_CW-1:0] col_dec;

    // Simple step results
    logic [CUR_CW-1:0] s_col_n;
    logic [ROW_W-1:0]  s_row_n;
    logic              s_we;
    logic [ROW_W-1:0]  s_wr_row;
    logic [COL_AW-1:0] s_wr_col;
    logic [7:0]        s_wr_data;

    logic [ROW_W1-1:0] wr_sum, rd_sum;
    logic [ROW_W-1:0]  wr_phys, rd_phys;

    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    logic [7:0]        mem_wdata;
    logic [ADDR_W-1:0] rd_addr;

    // Capture the accepted beat
    always_ff @(posedge aclk) begin
        if (cmd.item_load) begin
            cmd_reg <= s_cmd;
            ch_reg  <= s_ch;
            rr_reg  <= s_read_row;
            rc_reg  <= s_read_col;
        end
    end

    // Decode the held beat against the cursor
    always_comb begin
        printable   = (ch_reg >= CH_SPACE) && (ch_reg <= CH_TILDE);
        put         = (cmd_reg == CMD_PUT) ||
                      ((cmd_reg == CMD_KEY) && (printable || (ch_reg == CH_CR)));
        pc          = ((cmd_reg == CMD_KEY) && (ch_reg == CH_CR)) ? CH_LF : ch_reg;
        put_lf      = put && (pc == CH_LF);
        put_cr      = put && (pc == CH_CR);
        put_wr      = put && !put_lf && !put_cr;
        bs          = (cmd_reg == CMD_KEY) && (ch_reg == CH_BS);
        line_full   = (col_reg == COLS_C);
        at_bottom   = (row_reg == ROW_LAST);
        rd_in_range = ({1'b0, rr_reg} < ROWS_L) && (CUR_CW'(rc_reg) < COLS_C);
        row_inc     = row_reg + ROW_W'(1);
        col_dec     = col_reg - CUR_CW'(1);

        if (cmd_reg == CMD_CLEAR) begin
            plan_sel = PLAN_CLEAR;
        end else if ((cmd_reg == CMD_READ) && rd_in_range) begin
            plan_sel = PLAN_READ;
        end else if (at_bottom && (put_lf || (put_wr && line_full))) begin
            plan_sel = PLAN_SCROLL;
        end else begin
            plan_sel = PLAN_SIMPLE;
        end
    end

    // Cursor move and cell write for a step without scroll
    always_comb begin
        s_col_n   = col_reg;
        s_row_n   = row_reg;
        s_we      = 1'b0;
        s_wr_row  = row_reg;
        s_wr_col  = col_reg[COL_AW-1:0];
        s_wr_data = pc;
        priority if (put_lf) begin
            s_row_n = row_inc;
            s_col_n = '0;
        end else if (put_cr) begin
            s_col_n = '0;
        end else if (put_wr && line_full) begin
            s_row_n  = row_inc;
            s_col_n  = CUR_CW'(1);
            s_we     = 1'b1;
            s_wr_row = row_inc;
            s_wr_col = '0;
        end else if (put_wr) begin
            s_col_n = col_reg + CUR_CW'(1);
            s_we    = 1'b1;
        end else if (bs && (col_reg != '0)) begin
            s_col_n   = col_dec;
            s_we      = 1'b1;
            s_wr_col  = col_dec[COL_AW-1:0];
            s_wr_data = CH_SPACE;
        end else begin
            // Ignored key, read or clear: hold the cursor and the grid
            s_we = 1'b0;
        end
    end

    // Map logical rows onto physical rows
    always_comb begin
        wr_sum  = {1'b0, s_wr_row} + {1'b0, top_reg};
        wr_phys = (wr_sum >= ROWS_L) ? ROW_W'(wr_sum - ROWS_L) : wr_sum[ROW_W-1:0];
        rd_sum  = {1'b0, rr_reg} + {1'b0, top_reg};
        rd_phys = (rd_sum >= ROWS_L) ? ROW_W'(rd_sum - ROWS_L) : rd_sum[ROW_W-1:0];
        rd_addr = {rd_phys, rc_reg};
    end

    // Select the memory write
    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = {sw_row_reg, sw_col_reg};
        mem_wdata = CH_SPACE;
        priority if (cmd.sweep_step) begin
            mem_we    = 1'b1;
            mem_waddr = cmd.sweep_one_row ? {top_reg, sw_col_reg} : {sw_row_reg, sw_col_reg};
        end else if (cmd.simple_commit && s_we) begin
            mem_we    = 1'b1;
            mem_waddr = {wr_phys, s_wr_col};
            mem_wdata = s_wr_data;
        end else if (cmd.scroll_finish && put_wr) begin
            mem_we    = 1'b1;
            mem_waddr = {top_reg, COL_AW'(0)};
            mem_wdata = pc;
        end else begin
            // No write this cycle
            mem_we = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.read_issue) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // Advance the fill sweep
    always_comb begin
        col_end     = (sw_col_reg == COL_LAST);
        all_end     = col_end && (sw_row_reg == ROW_LAST);
        sw_col_next = sw_col_reg;
        sw_row_next = sw_row_reg;
        if (cmd.sweep_step) begin
            if (col_end) begin
                sw_col_next = '0;
                if (!cmd.sweep_one_row) begin
                    sw_row_next = (sw_row_reg == ROW_LAST) ? '0 : sw_row_reg + ROW_W'(1);
                end
            end else begin
                sw_col_next = sw_col_reg + COL_AW'(1);
            end
        end
    end

    // Cursor, rotation and result selection
    always_comb begin
        col_next  = col_reg;
        row_next  = row_reg;
        top_next  = top_reg;
        load      = 1'b0;
        load_col  = col_reg;
        load_row  = row_reg;
        load_cell = '0;
        load_sc   = 1'b0;
        priority if (cmd.simple_commit) begin
            col_next = s_col_n;
            row_next = s_row_n;
            load     = 1'b1;
            load_col = s_col_n;
            load_row = s_row_n;
        end else if (cmd.read_finish) begin
            load      = 1'b1;
            load_cell = rd_data_reg;
        end else if (cmd.scroll_finish) begin
            col_next = put_wr ? CUR_CW'(1) : '0;
            row_next = ROW_LAST;
            top_next = (top_reg == ROW_LAST) ? '0 : top_reg + ROW_W'(1);
            load     = 1'b1;
            load_col = put_wr ? CUR_CW'(1) : '0;
            load_row = ROW_LAST;
            load_sc  = 1'b1;
        end else if (cmd.clear_finish) begin
            col_next = '0;
            row_next = '0;
            top_next = '0;
            load     = 1'b1;
            load_col = '0;
            load_row = '0;
        end else begin
            // Nothing finishes: hold cursor and result
            load = 1'b0;
        end
    end

    // Drop the result on a taken beat, set it on a load
    always_comb begin
        out_free     = !m_valid_reg || m_ready;
        m_valid_next = load ? 1'b1 : (m_ready ? 1'b0 : m_valid_reg);
    end

    assign stat = '{plan: plan_sel, out_free: out_free, col_end: col_end, all_end: all_end};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg     <= '0;
            row_reg     <= '0;
            top_reg     <= '0;
            sw_col_reg  <= '0;
            sw_row_reg  <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            col_reg     <= col_next;
            row_reg     <= row_next;
            top_reg     <= top_next;
            sw_col_reg  <= sw_col_next;
            sw_row_reg  <= sw_row_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            m_col_reg  <= load_col;
            m_row_reg  <= load_row;
            m_cell_reg <= load_cell;
            m_sc_reg   <= load_sc;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_cursor_col = m_col_reg;
    assign m_cursor_row = m_row_reg;
    assign m_cell_char  = m_cell_reg;
    assign m_scrolled   = m_sc_reg;

endmodule

`default_nettype wire

// ===== src/text_terminal_cell_writer_top.sv =====
// ----------------------------------------------------------------------------
// text_terminal_cell_writer_top
// Character grid and cursor of a text terminal, one result beat per command.
//
//   channel  direction  ports
//   s_       in         s_valid/s_ready, s_cmd, s_ch, s_read_row, s_read_col
//   m_       out        m_valid/m_ready, m_cursor_col, m_cursor_row,
//                       m_cell_char, m_scrolled
//
// Put, key, ignored key and out-of-range read finish in the decode state; a read
// adds a memory read state. Scroll blanks one grid row through the memory
// write port one cell a cycle (the top row pointer rotates, no rows move).
// Clear: one cell written per cycle.
// After reset a clearing pass over all ROWS*COLS cells (2400 by default) runs
// with s_ready low. A stalled m_ stage holds the next beat in decode.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module text_terminal_cell_writer_top #(
    parameter int COLS = ttcw_pkg::TTCW_COLS,
    parameter int ROWS = ttcw_pkg::TTCW_ROWS
) (
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    input  wire logic                    s_valid,
    output logic                         s_ready,
    input  wire logic [1:0]              s_cmd,
    input  wire logic [7:0]              s_ch,
    input  wire logic [$clog2(ROWS)-1:0] s_read_row,
    input  wire logic [$clog2(COLS)-1:0] s_read_col,
    output logic                         m_valid,
    input  wire logic                    m_ready,
    output logic [$clog2(COLS+1)-1:0]    m_cursor_col,
    output logic [$clog2(ROWS)-1:0]      m_cursor_row,
    output logic [7:0]                   m_cell_char,
    output logic                         m_scrolled
);
    import ttcw_pkg::*;

    localparam int ROW_W  = $clog2(ROWS);
    localparam int CUR_CW = $clog2(COLS + 1);

    ttcw_cmd_t  ctl_cmd;
    ttcw_stat_t dp_stat;
    logic       any_load;

    ttcw_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (dp_stat),
        .cmd     (ctl_cmd)
    );

    ttcw_dp #(
        .COLS (COLS),
        .ROWS (ROWS)
    ) u_dp (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_cmd        (s_cmd),
        .s_ch         (s_ch),
        .s_read_row   (s_read_row),
        .s_read_col   (s_read_col),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_cursor_col (m_cursor_col),
        .m_cursor_row (m_cursor_row),
        .m_cell_char  (m_cell_char),
        .m_scrolled   (m_scrolled),
        .cmd          (ctl_cmd),
        .stat         (dp_stat)
    );

    assign any_load = ctl_cmd.simple_commit || ctl_cmd.read_finish ||
                      ctl_cmd.scroll_finish || ctl_cmd.clear_finish;

    // A result is only loaded into a free output stage
    `ASSERT_SAME(a_load_free, aclk, aresetn, any_load, (!m_valid || m_ready), "result overwritten")
    // One beat in flight: ready drops after an accept
    `ASSERT_NEXT(a_one_beat, aclk, aresetn, (s_valid && s_ready), !s_ready, "second beat taken")
    // Reported cursor stays inside the grid
    `ASSERT_SAME(a_cur_range, aclk, aresetn, m_valid, ((m_cursor_col <= CUR_CW'(COLS)) && ({1'b0, m_cursor_row} < (ROW_W + 1)'(ROWS))), "cursor out of range")
    // A scroll leaves the cursor on the last row
    `ASSERT_SAME(a_scroll_row, aclk, aresetn, (m_valid && m_scrolled), (m_cursor_row == ROW_W'(ROWS - 1)), "scroll row wrong")

endmodule

`default_nettype wire
